// ----- sv/ppm_pulse_train_generator_macros.svh -----
`ifndef PPM_PULSE_TRAIN_GENERATOR_MACROS_SVH
`define PPM_PULSE_TRAIN_GENERATOR_MACROS_SVH

// Same-cycle implication, reported with $error.
`define PPM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reported with $error.
`define PPM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ppm_pkg.sv -----
`default_nettype none

package ppm_pkg;

  localparam int OPCODE_W    = 2;
  localparam int CH_IDX_W    = 4;
  localparam int DATA_W      = 16;
  localparam int NCH_W       = 5;
  localparam int ELAPSED_W   = 24;
  localparam int PCT_W       = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET_RAW = 2'd0,
    OP_SET_PCT = 2'd1,
    OP_EXPIRY  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NUM_CHANNELS = 3'd0,
    CFG_INVERTED     = 3'd1,
    CFG_PULSE_LEN    = 3'd2,
    CFG_FRAME_LEN    = 3'd3,
    CFG_MIN_WIDTH    = 3'd4,
    CFG_MAX_WIDTH    = 3'd5
  } cfg_index_t;

  localparam logic [NCH_W-1:0]  RST_NUM_CHANNELS = 5'd8;
  localparam logic              RST_INVERTED     = 1'b0;
  localparam logic [DATA_W-1:0] RST_PULSE_LEN    = 16'd500;
  localparam logic [DATA_W-1:0] RST_FRAME_LEN    = 16'd22500;
  localparam logic [DATA_W-1:0] RST_MIN_WIDTH    = 16'd1000;
  localparam logic [DATA_W-1:0] RST_MAX_WIDTH    = 16'd2000;
  localparam logic [DATA_W-1:0] RST_CH_WIDTH     = 16'd1000;

  localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

  // x / 100 for x < 2^23: (x * floor(2^30 / 100)) >> 30 is exact or one low
  localparam int              PROD_W      = 23;
  localparam int              RECIP_W     = 24;
  localparam int              RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd10737418;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [NCH_W-1:0]  num_channels;
    logic              inverted;
    logic [DATA_W-1:0] pulse_len_us;
    logic [DATA_W-1:0] frame_len_us;
    logic [DATA_W-1:0] min_width_us;
    logic [DATA_W-1:0] max_width_us;
  } cfg_t;

  typedef struct packed {
    opcode_t             op;
    logic [CH_IDX_W-1:0] idx;
    logic [DATA_W-1:0]   value;
  } qitem_t;

  typedef struct packed {
    logic   push;
    qitem_t item;
  } qpush_t;

  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

endpackage

`default_nettype wire

// ----- sv/ppm_if.sv -----
`default_nettype none

interface ppm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  channel_index;
  logic [15:0] value;

  modport source (output valid, opcode, channel_index, value, input ready);
  modport sink   (input valid, opcode, channel_index, value, output ready);
endinterface

interface ppm_result_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [15:0] interval_us;
  logic        sync_gap;

  modport source (output valid, pin_level, interval_us, sync_gap, input ready);
  modport sink   (input valid, pin_level, interval_us, sync_gap, output ready);
endinterface

`default_nettype wire

// ----- sv/ppm_pulse_train_generator.sv -----
// Channel   Dir  Payload                               Handshake
// items     in   opcode, channel_index, value          valid / ready
// results   out  pin_level, interval_us, sync_gap      valid / ready
// wr_*      in   wr_index, wr_data                     wr_en, no wait
//
// One item per cycle sustained while results are taken; an expiry result passes
// through the 2-entry queue, the 4-stage width pipeline and the result register.
// Channel writes and expiries go through the same in-order pipeline, so an
// expiry always sees every earlier write. The percent divide by 100 is a
// reciprocal multiply with one correction step across stages 2 and 3.
// rst (sync) restores register defaults, all widths to 1000 and the frame.
// A held result stalls the pipeline; the queue then fills and drops ready.
`default_nettype none

module ppm_pulse_train_generator
  import ppm_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  ppm_item_if.sink               items,
  ppm_result_if.source           results,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  cfg_t   cfg;
  qpush_t push;
  qhead_t head;
  logic   q_full;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_channels <= RST_NUM_CHANNELS;
      cfg.inverted     <= RST_INVERTED;
      cfg.pulse_len_us <= RST_PULSE_LEN;
      cfg.frame_len_us <= RST_FRAME_LEN;
      cfg.min_width_us <= RST_MIN_WIDTH;
      cfg.max_width_us <= RST_MAX_WIDTH;
    end else if (wr_en) begin
      case (wr_index)
        CFG_NUM_CHANNELS: cfg.num_channels <= wr_data[NCH_W-1:0];
        CFG_INVERTED:     cfg.inverted     <= wr_data[0];
        CFG_PULSE_LEN:    cfg.pulse_len_us <= wr_data;
        CFG_FRAME_LEN:    cfg.frame_len_us <= wr_data;
        CFG_MIN_WIDTH:    cfg.min_width_us <= wr_data;
        CFG_MAX_WIDTH:    cfg.max_width_us <= wr_data;
        default:          ;
      endcase
    end
  end

  ppm_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .items  (items),
    .q_full (q_full),
    .push   (push)
  );

  ppm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  ppm_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

`default_nettype wire

// ----- sv/ppm_front.sv -----
`default_nettype none

module ppm_front
  import ppm_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
) (
  ppm_item_if.sink items,
  input  logic     q_full,
  output qpush_t   push
);

  localparam logic [5:0] MAX_CH = 6'(MAX_CHANNELS);

  logic in_range;
  logic keep;

  assign in_range = ({2'b00, items.channel_index} < MAX_CH);

  // drop unused opcodes and writes past the store before they take a slot
  always_comb begin
    keep = 1'b0;
    case (items.opcode)
      OP_SET_RAW: keep = in_range;
      OP_SET_PCT: keep = in_range;
      OP_EXPIRY:  keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  always_comb begin
    push.item.op  = opcode_t'(items.opcode);
    push.item.idx = items.channel_index;
    if (items.opcode == OP_SET_PCT && items.value > DATA_W'(PERCENT_FULL)) begin
      push.item.value = DATA_W'(PERCENT_FULL);
    end else begin
      push.item.value = items.value;
    end
    push.push = items.valid && !q_full && keep;
  end

  assign items.ready = !q_full;

endmodule

`default_nettype wire

// ----- sv/ppm_queue.sv -----
`default_nettype none

module ppm_queue
  import ppm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qpush_t push,
  output logic   full,
  input  logic   pop,
  output qhead_t head
);

  qitem_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_comb begin
    case ({push.push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ppm_back.sv -----
`default_nettype none
`include "ppm_pulse_train_generator_macros.svh"

module ppm_back
  import ppm_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  qhead_t head,
  output logic  pop,
  ppm_result_if.source results
);

  localparam int         IDXW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [5:0] MAX_CH = 6'(MAX_CHANNELS);
  localparam int         MUL_W  = PROD_W + RECIP_W;

  typedef struct packed {
    logic                vld;
    opcode_t             op;
    logic [CH_IDX_W-1:0] idx;
    logic [DATA_W-1:0]   value;
  } tag_t;

  logic advance;

  // stage 1: percent times |max - min|
  tag_t              st1;
  logic              st1_neg;
  logic [PROD_W-1:0] st1_x;
  // stage 2: reciprocal estimate of x / 100
  tag_t              st2;
  logic              st2_neg;
  logic [PROD_W-1:0] st2_x;
  logic [DATA_W-1:0] st2_qe;
  // stage 3: corrected, signed quotient or raw width
  tag_t              st3;
  logic signed [17:0] st3_v;
  // stage 4: clamped width
  tag_t              st4;
  logic [DATA_W-1:0] st4_w;

  logic              d_neg;
  logic [DATA_W-1:0] d_mag;
  logic [PROD_W-1:0] prod1;
  logic [MUL_W-1:0]  rprod;
  logic [PROD_W-1:0] qe100;
  logic [PROD_W-1:0] rem;
  logic [DATA_W-1:0] q;
  logic signed [17:0] qs;
  logic signed [17:0] v;
  logic signed [17:0] sum;
  logic signed [17:0] min_s;
  logic signed [17:0] max_s;
  logic [DATA_W-1:0] w_clamped;

  // frame state
  logic                 pulse_phase;
  logic                 pulse_phase_next;
  logic [NCH_W-1:0]     channel_pos;
  logic [NCH_W-1:0]     channel_pos_next;
  logic [ELAPSED_W-1:0] elapsed_us;
  logic [ELAPSED_W-1:0] elapsed_us_next;
  logic [DATA_W-1:0]    widths [MAX_CHANNELS];

  logic                 commit_exp;
  logic                 commit_wr;
  logic [5:0]           count_lim;
  logic                 pos_done;
  logic [IDXW-1:0]      wr_sel;
  logic [IDXW-1:0]      rd_sel;
  logic [DATA_W-1:0]    cur_w;
  logic [ELAPSED_W-1:0] gap_e;
  logic                 res_level;
  logic [DATA_W-1:0]    res_interval;
  logic                 res_sync;

  // the whole line moves only when the result register can take a new item
  assign advance = !results.valid || results.ready;
  assign pop     = advance && head.valid;

  // ---- stage 1
  always_comb begin
    d_neg = (cfg.min_width_us > cfg.max_width_us);
    d_mag = d_neg ? (cfg.min_width_us - cfg.max_width_us)
                  : (cfg.max_width_us - cfg.min_width_us);
    prod1 = PROD_W'(head.item.value[PCT_W-1:0]) * PROD_W'(d_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.vld <= 1'b0;
    end else if (advance) begin
      st1     <= {head.valid, head.item.op, head.item.idx, head.item.value};
      st1_neg <= d_neg;
      st1_x   <= prod1;
    end
  end

  // ---- stage 2
  assign rprod = MUL_W'(st1_x) * MUL_W'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      st2.vld <= 1'b0;
    end else if (advance) begin
      st2     <= st1;
      st2_neg <= st1_neg;
      st2_x   <= st1_x;
      st2_qe  <= rprod[RECIP_SHIFT +: DATA_W];
    end
  end

  // ---- stage 3: estimate is exact or one low; division truncates toward zero
  always_comb begin
    qe100 = PROD_W'(st2_qe) * PROD_W'(PERCENT_FULL);
    rem   = st2_x - qe100;
    q     = (rem >= PROD_W'(PERCENT_FULL)) ? (st2_qe + 1'b1) : st2_qe;
    qs    = st2_neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    v     = (st2.op == OP_SET_PCT) ? qs : $signed({2'b00, st2.value});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st3.vld <= 1'b0;
    end else if (advance) begin
      st3   <= st2;
      st3_v <= v;
    end
  end

  // ---- stage 4: offset a percent width by min, then clamp (min tested first)
  always_comb begin
    min_s = $signed({2'b00, cfg.min_width_us});
    max_s = $signed({2'b00, cfg.max_width_us});
    sum   = (st3.op == OP_SET_PCT) ? (st3_v + min_s) : st3_v;
    if (sum < min_s) begin
      w_clamped = cfg.min_width_us;
    end else if (sum > max_s) begin
      w_clamped = cfg.max_width_us;
    end else begin
      w_clamped = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st4.vld <= 1'b0;
    end else if (advance) begin
      st4   <= st3;
      st4_w <= w_clamped;
    end
  end

  // ---- commit: store write or timer expiry
  assign commit_exp = advance && st4.vld && (st4.op == OP_EXPIRY);
  assign commit_wr  = advance && st4.vld && (st4.op == OP_SET_RAW || st4.op == OP_SET_PCT);
  assign wr_sel     = IDXW'(st4.idx);
  assign rd_sel     = channel_pos[IDXW-1:0];
  assign cur_w      = widths[rd_sel];

  always_comb begin
    count_lim = ({1'b0, cfg.num_channels} > MAX_CH) ? MAX_CH : {1'b0, cfg.num_channels};
    pos_done  = ({1'b0, channel_pos} >= count_lim);
    gap_e     = elapsed_us + ELAPSED_W'(cfg.pulse_len_us);
  end

  // next state of the frame sequencer
  always_comb begin
    pulse_phase_next = !pulse_phase;
    channel_pos_next = channel_pos;
    elapsed_us_next  = elapsed_us;
    if (!pulse_phase) begin
      if (pos_done) begin
        channel_pos_next = '0;
        elapsed_us_next  = '0;
      end else begin
        channel_pos_next = channel_pos + 1'b1;
        elapsed_us_next  = elapsed_us + ELAPSED_W'(cur_w);
      end
    end
  end

  // result of this expiry
  always_comb begin
    res_sync = 1'b0;
    if (pulse_phase) begin
      res_level    = cfg.inverted;
      res_interval = cfg.pulse_len_us;
    end else begin
      res_level = !cfg.inverted;
      if (pos_done) begin
        res_sync     = 1'b1;
        res_interval = (gap_e >= ELAPSED_W'(cfg.frame_len_us)) ? '0
                       : (cfg.frame_len_us - gap_e[DATA_W-1:0]);
      end else begin
        res_interval = (cur_w > cfg.pulse_len_us) ? (cur_w - cfg.pulse_len_us) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_phase <= 1'b1;
      channel_pos <= '0;
      elapsed_us  <= '0;
    end else if (commit_exp) begin
      pulse_phase <= pulse_phase_next;
      channel_pos <= channel_pos_next;
      elapsed_us  <= elapsed_us_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        widths[i] <= RST_CH_WIDTH;
      end
    end else if (commit_wr) begin
      widths[wr_sel] <= st4_w;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (commit_exp) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_exp) begin
      results.pin_level   <= res_level;
      results.interval_us <= res_interval;
      results.sync_gap    <= res_sync;
    end
  end

  `PPM_ASSERT_NEXT(a_phase_toggles, clk, rst, commit_exp, pulse_phase != $past(pulse_phase), "expiry did not toggle phase")
  `PPM_ASSERT_NEXT(a_sync_restarts, clk, rst, commit_exp && !pulse_phase && pos_done, channel_pos == '0 && elapsed_us == '0, "sync gap did not restart the frame")
  `PPM_ASSERT_NOW(a_pos_bounded, clk, rst, 1'b1, 6'(channel_pos) <= MAX_CH, "channel position past the store")

endmodule

`default_nettype wire
